### src/b64e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, widths and the character table of the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // Width of the per-message character counter
  localparam int COUNT_WIDTH = 16;
  // Field widths
  localparam int CHAR_W      = 7;
  localparam int CAP_W       = 16;
  localparam int OUT_CNT_W   = 16;
  // Width for the capacity compare, with room for the count plus two
  localparam int CMP_W       = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;  // '='
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 7'h2B;  // '+'
  localparam logic [CHAR_W-1:0] SLASH_CHAR = 7'h2F;  // '/'

  // Position of the next byte within its three-byte group
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // One classified byte: up to four characters, index of the final one
  typedef struct packed {
    logic [3:0][CHAR_W-1:0] chars;
    logic [1:0]             last_idx;
    logic                   msg_last;
  } job_t;

  // Map a 6-bit code to its alphabet character
  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] idx);
    logic [CHAR_W-1:0] ext;
    ext = {1'b0, idx};
    if (idx < 6'd26)      b64_char = ext + 7'h41;          // 'A'..'Z'
    else if (idx < 6'd52) b64_char = ext + 7'h47;          // 'a'..'z'
    else if (idx < 6'd62) b64_char = ext - 7'd4;           // '0'..'9'
    else if (idx == 6'd62) b64_char = PLUS_CHAR;
    else                  b64_char = SLASH_CHAR;
  endfunction

endpackage

### src/b64e_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_in_if
// Byte channel into the encoder: one message byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### src/b64e_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_out_if
// Character channel out of the encoder, one character per item.
// ----------------------------------------------------------------------------
interface b64e_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  out_char;
  logic        run_last;
  logic        message_end;
  logic        overflow;
  logic [15:0] char_count;

  modport source (output valid, output out_char, output run_last, output message_end,
                  output overflow, output char_count, input ready);
  modport sink   (input valid, input out_char, input run_last, input message_end,
                  input overflow, input char_count, output ready);
endinterface

### src/base64_stream_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// Streaming base64 encoder with standard alphabet, padding and capacity check.
// ----------------------------------------------------------------------------
// A byte item is accepted in any cycle while the two-entry queue behind the
// front part has room, so bytes may arrive back to back. Each byte yields one
// to four character items (one or two mid-group, plus the tail and one or two
// '=' on the last byte); characters leave at one per cycle from the output
// register while the receiver is ready, so the sustained rate is set by that
// single character port. The first character of a byte passes through the
// queue and then the output register before it is valid on the output. Once a
// message would exceed the capacity (terminator slot included), its remaining
// characters read as zero with overflow set; state clears at message end.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  b64e_in_if.sink                     in_ch,
  b64e_out_if.source                  out_ch,
  input  logic                        cfg_write_en,
  input  logic [b64e_pkg::CAP_W-1:0]  cfg_write_data
);
  import b64e_pkg::*;

  job_t push_job, head_job;
  logic q_push, q_pop, q_full, q_empty;

  // Classify bytes
  b64e_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  // Decouple front and back
  b64e_job_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .job_in  (push_job),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (head_job),
    .empty   (q_empty)
  );

  // Emit characters
  b64e_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .q_job          (head_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_ch         (out_ch)
  );

endmodule

### src/b64e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, tracks the group phase and carry bits, and builds the list
// of characters each byte produces, including tail and padding.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic            clk,
  input  logic            rst_n,
  b64e_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            q_push,
  output b64e_pkg::job_t  q_job
);
  import b64e_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  phase_t     grp_phase;
  logic [3:0] grp_carry;
  logic [7:0] b;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign b           = in_ch.data_byte;

  // Classify the byte against the current phase
  always_comb begin
    q_job       = '0;
    q_job.chars = {4{PAD_CHAR}};
    grp_phase   = PH_SECOND;
    grp_carry   = '0;
    unique case (phase_r)
      PH_SECOND: begin
        q_job.chars[0] = b64_char({carry_r[1:0], b[7:4]});
        q_job.last_idx = 2'd0;
        grp_phase      = PH_THIRD;
        grp_carry      = b[3:0];
      end
      PH_THIRD: begin
        q_job.chars[0] = b64_char({carry_r, b[7:6]});
        q_job.chars[1] = b64_char(b[5:0]);
        q_job.last_idx = 2'd1;
        grp_phase      = PH_FIRST;
        grp_carry      = '0;
      end
      default: begin
        q_job.chars[0] = b64_char(b[7:2]);
        q_job.last_idx = 2'd0;
        grp_phase      = PH_SECOND;
        grp_carry      = {2'b00, b[1:0]};
      end
    endcase

    // Append the final partial character and padding on the last byte
    q_job.msg_last = in_ch.last_byte;
    if (in_ch.last_byte) begin
      if (grp_phase == PH_SECOND) begin
        q_job.chars[1] = b64_char({grp_carry[1:0], 4'b0000});
        q_job.chars[2] = PAD_CHAR;
        q_job.chars[3] = PAD_CHAR;
        q_job.last_idx = 2'd3;
      end else if (grp_phase == PH_THIRD) begin
        q_job.chars[1] = b64_char({grp_carry, 2'b00});
        q_job.chars[2] = PAD_CHAR;
        q_job.last_idx = 2'd2;
      end
    end

    phase_nxt = phase_r;
    carry_nxt = carry_r;
    if (q_push) begin
      phase_nxt = in_ch.last_byte ? PH_FIRST : grp_phase;
      carry_nxt = in_ch.last_byte ? 4'd0 : grp_carry;
    end
  end

  // Hold group state between bytes; clear it at message end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      carry_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

### src/b64e_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_job_fifo
// Two-entry queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module b64e_job_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64e_pkg::job_t  job_in,
  output logic            full,
  input  logic            pop,
  output b64e_pkg::job_t  job_out,
  output logic            empty
);
  import b64e_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign job_out = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= job_in;
  end

endmodule

### src/b64e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Emits the queued characters one per cycle, while the receiver is ready,
// through an output register, applying the capacity check and keeping the
// per-message count.
module b64e_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [b64e_pkg::CAP_W-1:0]    cfg_write_data,
  input  b64e_pkg::job_t                q_job,
  input  logic                          q_empty,
  output logic                          q_pop,
  b64e_out_if.source                    out_ch
);
  import b64e_pkg::*;

  logic [CAP_W-1:0]       cap_r;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [1:0]             k_r, k_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      char_r;
  logic                   run_last_r, msg_end_r, ovf_out_r;
  logic [OUT_CNT_W-1:0]   count_out_r;

  logic                   advance, load, fin, ovf_now;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [CMP_W-1:0]       need;

  assign advance = !out_valid_r || out_ch.ready;
  assign load    = advance && !q_empty;
  assign fin     = (k_r == q_job.last_idx);
  assign q_pop   = load && fin;

  // Check room for this character plus the terminator slot
  always_comb begin
    need    = CMP_W'(cnt_r) + CMP_W'(2);
    ovf_now = ovf_r || (cnt_r == {COUNT_WIDTH{1'b1}}) || (need > CMP_W'(cap_r));
    cnt_new = ovf_now ? cnt_r : cnt_r + 1'b1;

    out_valid_nxt = out_valid_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (fin) begin
        k_nxt = 2'd0;
        // drop message state after its final character
        cnt_nxt = q_job.msg_last ? '0 : cnt_new;
        ovf_nxt = q_job.msg_last ? 1'b0 : ovf_now;
      end else begin
        k_nxt   = k_r + 2'd1;
        cnt_nxt = cnt_new;
        ovf_nxt = ovf_now;
      end
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= {CAP_W{1'b1}};
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) cap_r <= cfg_write_data;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      char_r      <= ovf_now ? '0 : q_job.chars[k_r];
      run_last_r  <= fin;
      msg_end_r   <= fin && q_job.msg_last;
      ovf_out_r   <= ovf_now;
      count_out_r <= OUT_CNT_W'(cnt_new);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = char_r;
  assign out_ch.run_last    = run_last_r;
  assign out_ch.message_end = msg_end_r;
  assign out_ch.overflow    = ovf_out_r;
  assign out_ch.char_count  = count_out_r;

endmodule

### verif/base64_stream_encoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit_test
// Self-checking bench for the base64 stream encoder. Message bytes go in
// through the byte channel. An in-bench encoder works out the characters that
// each accepted byte should produce, including tail, padding, output capacity
// overflow and character count. Every character item that leaves the block is
// checked against the oldest expected one, field by field. Both handshakes
// idle at random, the receiver holds off once for a long stretch, and the
// capacity register is swept over its extremes between message runs.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit_test;
  import b64e_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 8;      // block latency plus margin
  localparam int DRAIN_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 250;     // long receiver hold-off
  localparam int RANDOM_BYTES = 420;
  localparam int IDLE_PERCENT = 8;
  localparam logic [CAP_W-1:0] CAP_MAX = 16'hFFFF;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One expected character item
  typedef struct packed {
    logic [CHAR_W-1:0]    ch;
    logic                 run_last;
    logic                 msg_end;
    logic                 ovf;
    logic [OUT_CNT_W-1:0] count;
  } char_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic             cfg_write_en;
  logic [CAP_W-1:0] cfg_write_data;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_stream_encoder_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  // Encoder state mirrored in the bench
  phase_t                 enc_phase;
  logic [3:0]             enc_carry;
  logic [COUNT_WIDTH-1:0] enc_emitted;
  logic                   enc_ovf;
  logic [CAP_W-1:0]       enc_capacity;

  char_item_t expected_chars[$];
  int errors = 0;
  int bytes_sent = 0;
  int hold_requests = 0;
  bit no_idle = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Count each mismatch and print a line for the first 40 of them
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("%0t ERROR: %s", $time, msg);
    end
  endtask

  function automatic logic [CHAR_W-1:0] alphabet_char(input logic [5:0] code);
    logic [7:0] c;
    c = ALPHABET[(63 - int'(code)) * 8 +: 8];
    return c[CHAR_W-1:0];
  endfunction

  // Apply the capacity check to one character and advance the count
  function automatic char_item_t encode_char(input logic [CHAR_W-1:0] code);
    char_item_t r;
    if (!enc_ovf && (enc_emitted == {COUNT_WIDTH{1'b1}} ||
        {2'b00, enc_emitted} + 18'd2 > {2'b00, enc_capacity})) begin
      enc_ovf = 1'b1;
    end
    if (enc_ovf) begin
      r.ch = '0;
    end else begin
      enc_emitted = enc_emitted + 1'b1;
      r.ch = code;
    end
    r.ovf = enc_ovf;
    r.count = enc_emitted[OUT_CNT_W-1:0];
    r.run_last = 1'b0;
    r.msg_end = 1'b0;
    return r;
  endfunction

  function automatic void clear_message_state();
    enc_phase = PH_FIRST;
    enc_carry = '0;
    enc_emitted = '0;
    enc_ovf = 1'b0;
  endfunction

  // Work out the characters one accepted byte produces
  function automatic void predict_byte(input logic [7:0] b, input logic last);
    char_item_t step_chars[$];
    char_item_t r;
    case (enc_phase)
      PH_SECOND: begin
        step_chars.push_back(encode_char(alphabet_char({enc_carry[1:0], b[7:4]})));
        enc_carry = b[3:0];
        enc_phase = PH_THIRD;
      end
      PH_THIRD: begin
        step_chars.push_back(encode_char(alphabet_char({enc_carry, b[7:6]})));
        step_chars.push_back(encode_char(alphabet_char(b[5:0])));
        enc_carry = '0;
        enc_phase = PH_FIRST;
      end
      default: begin
        step_chars.push_back(encode_char(alphabet_char(b[7:2])));
        enc_carry = {2'b00, b[1:0]};
        enc_phase = PH_SECOND;
      end
    endcase
    // Tail character and padding on the last byte
    if (last) begin
      if (enc_phase == PH_SECOND) begin
        step_chars.push_back(encode_char(alphabet_char({enc_carry[1:0], 4'b0000})));
        step_chars.push_back(encode_char(PAD_CHAR));
        step_chars.push_back(encode_char(PAD_CHAR));
      end else if (enc_phase == PH_THIRD) begin
        step_chars.push_back(encode_char(alphabet_char({enc_carry, 2'b00})));
        step_chars.push_back(encode_char(PAD_CHAR));
      end
    end
    r = step_chars.pop_back();
    r.run_last = 1'b1;
    r.msg_end = last;
    step_chars.push_back(r);
    foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
    if (last) clear_message_state();
  endfunction

  // Offer one byte, with an occasional gap before it, and wait for acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Stop offering, wait for every expected character, then let the block settle
  task automatic drain_results();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d expected characters never arrived",
                                expected_chars.size()));
      expected_chars.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    drain_results();
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    enc_capacity = value;
    cfg_write_en <= 1'b0;
  endtask

  // Fixed messages under the reset capacity: padding cases, field extremes,
  // the two non-letter characters
  task automatic test_padding_forms();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Overflow at the smallest capacities and exactly at the limit
  task automatic test_capacity_limits();
    set_capacity(16'd1);
    send_byte(8'h4D, 1'b1);
    set_capacity(16'd2);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    set_capacity(16'd5);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);
    // overflow must not carry into the next message
    send_byte(8'h80, 1'b1);
  endtask

  // Receiver holds off while the sender keeps offering bytes
  task automatic test_output_stall();
    set_capacity(CAP_MAX);
    no_idle = 1'b1;
    hold_requests++;
    send_message(25);
    send_message(14);
    no_idle = 1'b0;
  endtask

  // Random messages over several capacity settings
  task automatic test_random_messages();
    int target;
    int len;
    int phase_idx;
    target = bytes_sent + RANDOM_BYTES;
    phase_idx = 0;
    while (bytes_sent < target) begin
      case (phase_idx % 6)
        0: set_capacity(CAP_MAX);
        1: set_capacity(16'($urandom_range(1, 30)));
        2: set_capacity(16'($urandom_range(3, 12)));
        3: set_capacity(16'($urandom_range(1, 65535)));
        4: set_capacity(16'd1);
        default: set_capacity(16'($urandom_range(16, 80)));
      endcase
      // one run with no idling on the byte and character channels
      no_idle = (phase_idx == 2);
      for (int m = 0; m < 8 && bytes_sent < target; m++) begin
        if ($urandom_range(9) == 0) len = $urandom_range(13, 60);
        else len = $urandom_range(1, 12);
        send_message(len);
      end
      no_idle = 1'b0;
      phase_idx++;
    end
  endtask

  // Check each character item against the oldest expectation
  always @(posedge clk) begin
    char_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h", out_ch.out_char));
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.out_char !== want.ch)
          report_mismatch($sformatf("out_char %h, expected %h (count %0d)",
                                    out_ch.out_char, want.ch, want.count));
        if (out_ch.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, expected %b (count %0d)",
                                    out_ch.run_last, want.run_last, want.count));
        if (out_ch.message_end !== want.msg_end)
          report_mismatch($sformatf("message_end %b, expected %b (count %0d)",
                                    out_ch.message_end, want.msg_end, want.count));
        if (out_ch.overflow !== want.ovf)
          report_mismatch($sformatf("overflow %b, expected %b (count %0d)",
                                    out_ch.overflow, want.ovf, want.count));
        if (out_ch.char_count !== want.count)
          report_mismatch($sformatf("char_count %0d, expected %0d",
                                    out_ch.char_count, want.count));
      end
    end
  end

  // Drive ready: random idling, long hold-off on request
  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Bound the run
  initial begin
    #2_000_000;
    $display("base64_stream_encoder_unit test failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    enc_capacity = CAP_MAX;
    clear_message_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_padding_forms();
    test_capacity_limits();
    test_output_stall();
    test_random_messages();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("base64_stream_encoder_unit test passed");
    end else begin
      $display("base64_stream_encoder_unit test failed");
    end
    $finish;
  end

endmodule
